// ===== design/nrsa_pkg.sv =====
`timescale 1ns / 1ps

package nrsa_pkg;

   localparam int COORD_W      = 12;
   localparam int DIM_W        = 13;
   localparam int STRIDE_W     = 14;
   localparam int PROD_W       = COORD_W + DIM_W;
   localparam int LUMA_W       = 25;
   localparam int CHROMA_W     = 24;
   localparam int LUMA_PROD_W  = DIM_W + STRIDE_W;
   localparam int CHROMA_PROD_W = DIM_W - 1 + STRIDE_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 14;

   localparam logic [DIM_W-1:0]    RST_SRC_DIM = DIM_W'(2);
   localparam logic [DIM_W-1:0]    RST_DST_DIM = DIM_W'(1);
   localparam logic [STRIDE_W-1:0] RST_STRIDE  = STRIDE_W'(2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH     = 3'd0,
      CSR_SRC_HEIGHT    = 3'd1,
      CSR_LUMA_STRIDE   = 3'd2,
      CSR_CHROMA_STRIDE = 3'd3,
      CSR_OUT_WIDTH     = 3'd4,
      CSR_OUT_HEIGHT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] dst_x;
      logic [COORD_W-1:0] dst_y;
   } req_type;

   typedef struct packed {
      logic [LUMA_W-1:0]   luma_offset;
      logic [CHROMA_W-1:0] chroma_offset;
      logic                out_of_range;
   } rsp_type;

   // limited register values as seen by the datapath
   typedef struct packed {
      logic [DIM_W-1:0]    src_width;
      logic [DIM_W-1:0]    src_height;
      logic [STRIDE_W-1:0] luma_stride;
      logic [STRIDE_W-1:0] chroma_stride;
      logic [DIM_W-1:0]    out_width;
      logic [DIM_W-1:0]    out_height;
   } cfg_type;

   typedef struct packed {
      logic [PROD_W-1:0] rem_row;
      logic [PROD_W-1:0] rem_col;
      logic [DIM_W-1:0]  quo_row;
      logic [DIM_W-1:0]  quo_col;
      logic              oor;
   } div_type;

   typedef struct packed {
      logic [LUMA_PROD_W-1:0]   luma_prod;
      logic [CHROMA_PROD_W-1:0] chroma_prod;
      logic [DIM_W-1:0]         col;
      logic                     oor;
   } mul_type;

endpackage

// ===== design/nrsa_csr.sv =====
`timescale 1ns / 1ps

module nrsa_csr #(
   parameter int MAX_DIM    = 4096,
   parameter int MAX_STRIDE = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nrsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nrsa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output nrsa_pkg::cfg_type                cfg
);
   import nrsa_pkg::*;

   localparam int DIM_MAXV    = (1 << DIM_W) - 1;
   localparam int STRIDE_MAXV = (1 << STRIDE_W) - 1;
   localparam int DIM_LIMIT    = (MAX_DIM > DIM_MAXV) ? DIM_MAXV : MAX_DIM;
   localparam int STRIDE_LIMIT = (MAX_STRIDE > STRIDE_MAXV) ? STRIDE_MAXV : MAX_STRIDE;
   localparam logic [DIM_W-1:0]    DIM_CAP    = DIM_W'(DIM_LIMIT);
   localparam logic [STRIDE_W-1:0] STRIDE_CAP = STRIDE_W'(STRIDE_LIMIT);

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic [DIM_W-1:0]    wr_dim;
   logic [STRIDE_W-1:0] wr_stride;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      // store values already limited so the datapath sees them directly
      wr_dim    = (csr_wdata[DIM_W-1:0] > DIM_CAP) ? DIM_CAP : csr_wdata[DIM_W-1:0];
      wr_stride = (csr_wdata[STRIDE_W-1:0] > STRIDE_CAP) ? STRIDE_CAP
                                                         : csr_wdata[STRIDE_W-1:0];
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:     cfg_in.src_width     = wr_dim;
            CSR_SRC_HEIGHT:    cfg_in.src_height    = wr_dim;
            CSR_LUMA_STRIDE:   cfg_in.luma_stride   = wr_stride;
            CSR_CHROMA_STRIDE: cfg_in.chroma_stride = wr_stride;
            CSR_OUT_WIDTH:     cfg_in.out_width     = wr_dim;
            CSR_OUT_HEIGHT:    cfg_in.out_height    = wr_dim;
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width     <= RST_SRC_DIM;
         cfg_ff.src_height    <= RST_SRC_DIM;
         cfg_ff.luma_stride   <= RST_STRIDE;
         cfg_ff.chroma_stride <= RST_STRIDE;
         cfg_ff.out_width     <= RST_DST_DIM;
         cfg_ff.out_height    <= RST_DST_DIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/nrsa_div_stage.sv =====
`timescale 1ns / 1ps

module nrsa_div_stage #(
   parameter int BIT = 0
) (
   input  logic                       clock,
   input  logic                       en,
   input  nrsa_pkg::div_type          cur,
   input  logic [nrsa_pkg::DIM_W-1:0] row_div,
   input  logic [nrsa_pkg::DIM_W-1:0] col_div,
   output nrsa_pkg::div_type          nxt
);
   import nrsa_pkg::*;

   div_type           nxt_ff;
   div_type           nxt_in;
   logic [PROD_W:0]   row_sh;
   logic [PROD_W:0]   col_sh;
   logic [PROD_W:0]   row_diff;
   logic [PROD_W:0]   col_diff;
   logic [DIM_W-1:0]  quo_bit;

   assign nxt = nxt_ff;

   // one restoring step per lane: trial subtract of the divisor at this bit weight
   always_comb begin
      row_sh   = (PROD_W + 1)'(row_div) << BIT;
      col_sh   = (PROD_W + 1)'(col_div) << BIT;
      row_diff = {1'b0, cur.rem_row} - row_sh;
      col_diff = {1'b0, cur.rem_col} - col_sh;
      quo_bit  = DIM_W'(1) << BIT;
      nxt_in   = cur;
      if (!row_diff[PROD_W]) begin
         nxt_in.rem_row = row_diff[PROD_W-1:0];
         nxt_in.quo_row = cur.quo_row | quo_bit;
      end
      if (!col_diff[PROD_W]) begin
         nxt_in.rem_col = col_diff[PROD_W-1:0];
         nxt_in.quo_col = cur.quo_col | quo_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff <= nxt_in;
      end
   end

endmodule

// ===== design/nearest_resize_sample_address.sv =====
`timescale 1ns / 1ps

// Nearest-neighbour resize address generator for a semi-planar 4:2:0 source
// with interleaved V,U chroma. Each item is a destination coordinate; each
// result gives the luma byte offset and the V byte offset of the source
// sample (U follows at +1), or zero offsets with out_of_range set when the
// coordinate lies outside the destination size. One item is accepted every
// clock while the skid register is empty. Restoring dividers resolve the QW
// bits (log2 of min(MAX_DIM, 8192) rounded up) of the source row and column,
// one per stage. A skid register on the result side parks a waiting result,
// so the input stays open as it first waits; the pipeline holds while the
// skid register is full. csr_ready is always high; registers are to be
// written only while no item is in flight, which the block does not enforce.
// Values above MAX_DIM (low DIM_W bits) or MAX_STRIDE are limited to them.
module nearest_resize_sample_address #(
   parameter int MAX_DIM    = 4096,
   parameter int MAX_STRIDE = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  nrsa_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output nrsa_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nrsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nrsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nrsa_pkg::*;

   localparam int QUO_SPAN = (MAX_DIM > (1 << DIM_W)) ? (1 << DIM_W) : MAX_DIM;
   localparam int QW       = $clog2(QUO_SPAN);
   localparam int NSTAGE   = QW + 3;

   cfg_type             cfg;
   logic                en;
   logic [NSTAGE-1:0]   vld_ff;
   logic [NSTAGE-1:0]   vld_in;
   div_type             div_b_ff;
   div_type             div_b_in;
   div_type             div_pipe [QW+1];
   mul_type             mul_ff;
   mul_type             mul_in;
   rsp_type             out_ff;
   rsp_type             out_in;
   rsp_type             skid_ff;
   logic                skid_vld_ff;
   logic [DIM_W-1:0]    row;
   logic [DIM_W-1:0]    col;

   nrsa_csr #(
      .MAX_DIM    (MAX_DIM),
      .MAX_STRIDE (MAX_STRIDE)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign en        = !skid_vld_ff;
   assign req_ready = en;
   assign rsp_valid = skid_vld_ff | vld_ff[NSTAGE-1];
   assign rsp_data  = skid_vld_ff ? skid_ff : out_ff;
   assign vld_in    = {vld_ff[NSTAGE-2:0], req_valid};

   // range check and scaling products
   always_comb begin
      div_b_in.rem_row = PROD_W'(req_data.dst_y) * PROD_W'(cfg.src_height);
      div_b_in.rem_col = PROD_W'(req_data.dst_x) * PROD_W'(cfg.src_width);
      div_b_in.quo_row = '0;
      div_b_in.quo_col = '0;
      div_b_in.oor     = (cfg.out_width == '0) || (cfg.out_height == '0)
                         || (DIM_W'(req_data.dst_x) >= cfg.out_width)
                         || (DIM_W'(req_data.dst_y) >= cfg.out_height);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_b_ff <= div_b_in;
      end
   end

   assign div_pipe[0] = div_b_ff;

   for (genvar k = 0; k < QW; k++) begin : g_div
      nrsa_div_stage #(
         .BIT (QW - 1 - k)
      ) u_stage (
         .clock   (clock),
         .en      (en),
         .cur     (div_pipe[k]),
         .row_div (cfg.out_height),
         .col_div (cfg.out_width),
         .nxt     (div_pipe[k+1])
      );
   end

   // stride products
   always_comb begin
      row                = div_pipe[QW].quo_row;
      col                = div_pipe[QW].quo_col;
      mul_in.luma_prod   = LUMA_PROD_W'(row) * LUMA_PROD_W'(cfg.luma_stride);
      mul_in.chroma_prod = CHROMA_PROD_W'(row[DIM_W-1:1])
                           * CHROMA_PROD_W'(cfg.chroma_stride);
      mul_in.col         = col;
      mul_in.oor         = div_pipe[QW].oor;
   end

   // final sums; zero the offsets of an out-of-range item
   always_comb begin
      out_in.out_of_range  = mul_ff.oor;
      out_in.luma_offset   = LUMA_W'(mul_ff.luma_prod + LUMA_PROD_W'(mul_ff.col));
      out_in.chroma_offset = CHROMA_W'(mul_ff.chroma_prod
                             + CHROMA_PROD_W'({mul_ff.col[DIM_W-1:1], 1'b0}));
      if (mul_ff.oor) begin
         out_in.luma_offset   = '0;
         out_in.chroma_offset = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_ff  <= mul_in;
         out_ff  <= out_in;
         skid_ff <= out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff      <= vld_in;
         // park the shown item while the pipeline advances under it
         skid_vld_ff <= vld_ff[NSTAGE-1] & !rsp_ready;
      end else if (rsp_ready) begin
         skid_vld_ff <= 1'b0;
      end
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import nrsa_pkg::*;

   localparam int MAX_DIM     = 4096;
   localparam int MAX_STRIDE  = 8192;
   localparam int PIPE_CYCLES = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 115;
   localparam int REPORT_MAX  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = CSR_OUT_HEIGHT + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = CSR_SPARE_LO + 3'd1;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   value;
      req_type                 coord;
      bit                      typed;
      rsp_type                 golden;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // travels with each item so the monitor knows whether a typed-in result applies
   bit                     req_typed;
   rsp_type                req_golden;

   logic [DIM_W-1:0]       src_w_q = RST_SRC_DIM;
   logic [DIM_W-1:0]       src_h_q = RST_SRC_DIM;
   logic [STRIDE_W-1:0]    luma_stride_q = RST_STRIDE;
   logic [STRIDE_W-1:0]    chroma_stride_q = RST_STRIDE;
   logic [DIM_W-1:0]       dst_w_q = RST_DST_DIM;
   logic [DIM_W-1:0]       dst_h_q = RST_DST_DIM;

   rsp_type                offsets_due[$];
   stim_row_type           stim_rows[$];

   int                     errors = 0;
   int                     idle_cycles = 0;
   int                     items_sent = 0;
   int                     results_seen = 0;
   int                     oor_seen = 0;
   int                     csr_writes = 0;
   int                     settings_used = 1;
   bit                     hold_results = 1'b0;

   nearest_resize_sample_address uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned capped(int unsigned v, int unsigned lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic rsp_type sample_offsets(req_type c);
      int unsigned sw, sh, dw, dh, ls, cs, row, col;
      rsp_type     o;
      sw = capped(32'(src_w_q), MAX_DIM);
      sh = capped(32'(src_h_q), MAX_DIM);
      dw = capped(32'(dst_w_q), MAX_DIM);
      dh = capped(32'(dst_h_q), MAX_DIM);
      ls = capped(32'(luma_stride_q), MAX_STRIDE);
      cs = capped(32'(chroma_stride_q), MAX_STRIDE);
      o = '0;
      if (dw == 0 || dh == 0 || 32'(c.dst_x) >= dw || 32'(c.dst_y) >= dh) begin
         o.out_of_range = 1'b1;
      end else begin
         row = (32'(c.dst_y) * sh) / dh;
         col = (32'(c.dst_x) * sw) / dw;
         o.luma_offset   = LUMA_W'(row * ls + col);
         o.chroma_offset = CHROMA_W'((row / 2) * cs + (col / 2) * 2);
      end
      return o;
   endfunction

   task automatic flag(string what);
      errors++;
      if (errors <= REPORT_MAX) $display("%s", what);
   endtask

   always @(posedge clock) begin : monitor
      rsp_type due;
      if (reset) begin
         src_w_q = RST_SRC_DIM;
         src_h_q = RST_SRC_DIM;
         luma_stride_q = RST_STRIDE;
         chroma_stride_q = RST_STRIDE;
         dst_w_q = RST_DST_DIM;
         dst_h_q = RST_DST_DIM;
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (csr_valid && csr_ready) begin
            idle_cycles = 0;
            csr_writes++;
            case (csr_index)
               CSR_SRC_WIDTH:     src_w_q = csr_wdata[DIM_W-1:0];
               CSR_SRC_HEIGHT:    src_h_q = csr_wdata[DIM_W-1:0];
               CSR_LUMA_STRIDE:   luma_stride_q = csr_wdata[STRIDE_W-1:0];
               CSR_CHROMA_STRIDE: chroma_stride_q = csr_wdata[STRIDE_W-1:0];
               CSR_OUT_WIDTH:     dst_w_q = csr_wdata[DIM_W-1:0];
               CSR_OUT_HEIGHT:    dst_h_q = csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            idle_cycles = 0;
            items_sent++;
            offsets_due.push_back(req_typed ? req_golden : sample_offsets(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            results_seen++;
            if (rsp_data.out_of_range) oor_seen++;
            if (offsets_due.size() == 0) begin
               flag($sformatf("%0t: result with nothing due: luma %0d chroma %0d oor %0b",
                              $time, rsp_data.luma_offset, rsp_data.chroma_offset,
                              rsp_data.out_of_range));
            end else begin
               due = offsets_due.pop_front();
               if (rsp_data.luma_offset !== due.luma_offset ||
                   rsp_data.chroma_offset !== due.chroma_offset ||
                   rsp_data.out_of_range !== due.out_of_range) begin
                  flag($sformatf({"%0t: mismatch: expected luma %0d chroma %0d oor %0b, ",
                                  "got luma %0d chroma %0d oor %0b"}, $time,
                                 due.luma_offset, due.chroma_offset, due.out_of_range,
                                 rsp_data.luma_offset, rsp_data.chroma_offset,
                                 rsp_data.out_of_range));
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("tb_top: errors");
      $finish;
   end

   initial begin : result_sink
      int r;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_results) begin
            // hold off long enough for the pipeline to back up into the input
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            r = $urandom_range(99, 0);
            if (r < 55) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(20, 1)) @(posedge clock);
            end else if (r < 95) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(3, 1)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(40, 10)) @(posedge clock);
            end
         end
      end
   end

   function automatic int pick_gap(bit bursty);
      int r;
      if (bursty) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic req_type random_coord();
      int unsigned dw, dh, r;
      req_type     c;
      dw = capped(32'(dst_w_q), MAX_DIM);
      dh = capped(32'(dst_h_q), MAX_DIM);
      r = $urandom_range(99, 0);
      c.dst_x = COORD_W'($urandom);
      c.dst_y = COORD_W'($urandom);
      if (dw != 0 && dh != 0 && r < 90) begin
         c.dst_x = COORD_W'($urandom_range(dw - 1, 0));
         c.dst_y = COORD_W'($urandom_range(dh - 1, 0));
         // land on the column or row past the edge, or on the last one at MAX_DIM
         if (r >= 80) begin
            if ($urandom_range(1, 0)) c.dst_x = COORD_W'((dw < MAX_DIM) ? dw : dw - 1);
            else c.dst_y = COORD_W'((dh < MAX_DIM) ? dh : dh - 1);
         end
      end
      return c;
   endfunction

   function automatic void add_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      stim_row_type s;
      s.kind = ROW_CSR;
      s.index = idx;
      s.value = value;
      s.coord = '0;
      s.typed = 1'b0;
      s.golden = '0;
      stim_rows.push_back(s);
   endfunction

   function automatic void add_item(int unsigned x, int unsigned y);
      stim_row_type s;
      s.kind = ROW_ITEM;
      s.index = '0;
      s.value = '0;
      s.coord.dst_x = COORD_W'(x);
      s.coord.dst_y = COORD_W'(y);
      s.typed = 1'b0;
      s.golden = '0;
      stim_rows.push_back(s);
   endfunction

   function automatic void add_checked(int unsigned x, int unsigned y, int unsigned luma,
                                       int unsigned chroma, bit oor);
      stim_row_type s;
      s.kind = ROW_ITEM;
      s.index = '0;
      s.value = '0;
      s.coord.dst_x = COORD_W'(x);
      s.coord.dst_y = COORD_W'(y);
      s.typed = 1'b1;
      s.golden.luma_offset = LUMA_W'(luma);
      s.golden.chroma_offset = CHROMA_W'(chroma);
      s.golden.out_of_range = oor;
      stim_rows.push_back(s);
   endfunction

   task automatic send_item(req_type c, bit typed, rsp_type golden, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= c;
      req_typed  <= typed;
      req_golden <= golden;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      req_typed <= 1'b0;
      @(posedge clock);
      while (offsets_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_setting();
      int r;
      logic [CSR_DATA_W-1:0] sw, sh, ls, cs, dw, dh;
      r = $urandom_range(9, 0);
      sw = CSR_DATA_W'(2 * $urandom_range(MAX_DIM / 2, 1));
      sh = CSR_DATA_W'(2 * $urandom_range(MAX_DIM / 2, 1));
      ls = CSR_DATA_W'($urandom_range(MAX_STRIDE, 2));
      cs = CSR_DATA_W'($urandom_range(MAX_STRIDE, 2));
      dw = CSR_DATA_W'($urandom_range(MAX_DIM, 1));
      dh = CSR_DATA_W'($urandom_range(MAX_DIM, 1));
      case (r)
         0: begin
            sw = CSR_DATA_W'(MAX_DIM);
            sh = CSR_DATA_W'(MAX_DIM);
            ls = CSR_DATA_W'(MAX_STRIDE);
            cs = CSR_DATA_W'(MAX_STRIDE);
            dw = CSR_DATA_W'(MAX_DIM);
            dh = CSR_DATA_W'(MAX_DIM);
         end
         1: begin
            sw = CSR_DATA_W'($urandom_range(16383, MAX_DIM + 1));
            sh = CSR_DATA_W'($urandom_range(16383, MAX_DIM + 1));
            ls = CSR_DATA_W'($urandom_range(16383, MAX_STRIDE + 1));
            cs = CSR_DATA_W'($urandom_range(16383, MAX_STRIDE + 1));
            dw = CSR_DATA_W'($urandom_range(16383, MAX_DIM + 1));
            dh = CSR_DATA_W'($urandom_range(16383, MAX_DIM + 1));
         end
         2: begin
            sw = CSR_DATA_W'(2);
            sh = CSR_DATA_W'(2);
            ls = CSR_DATA_W'(2);
            cs = CSR_DATA_W'(2);
            dw = CSR_DATA_W'($urandom_range(4, 1));
            dh = CSR_DATA_W'($urandom_range(4, 1));
         end
         3: begin
            // odd source sizes with small strides, mostly narrower than a row
            sw = sw | 14'd1;
            sh = sh | 14'd1;
            ls = CSR_DATA_W'($urandom_range(64, 2));
            cs = CSR_DATA_W'($urandom_range(64, 2));
         end
         4: begin
            if ($urandom_range(1, 0)) dw = '0;
            else dh = '0;
         end
         5: begin
            dw = CSR_DATA_W'($urandom_range(64, 1));
            dh = CSR_DATA_W'($urandom_range(64, 1));
         end
         default: ;
      endcase
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_LUMA_STRIDE, ls);
      write_reg(CSR_CHROMA_STRIDE, cs);
      write_reg(CSR_OUT_WIDTH, dw);
      write_reg(CSR_OUT_HEIGHT, dh);
   endtask

   initial begin : stimulus
      bit wrote;
      bit bursty;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      req_typed  = 1'b0;
      req_golden = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      wrote      = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: only the origin is inside a 1x1 destination
      add_checked(0, 0, 0, 0, 1'b0);
      add_checked(1, 0, 0, 0, 1'b1);
      add_checked(0, 1, 0, 0, 1'b1);
      add_checked(4095, 4095, 0, 0, 1'b1);

      add_csr(CSR_SRC_WIDTH, CSR_DATA_W'(MAX_DIM));
      add_csr(CSR_SRC_HEIGHT, CSR_DATA_W'(MAX_DIM));
      add_csr(CSR_LUMA_STRIDE, CSR_DATA_W'(MAX_STRIDE));
      add_csr(CSR_CHROMA_STRIDE, CSR_DATA_W'(MAX_STRIDE));
      add_csr(CSR_OUT_WIDTH, CSR_DATA_W'(MAX_DIM));
      add_csr(CSR_OUT_HEIGHT, CSR_DATA_W'(MAX_DIM));
      add_checked(4095, 4095, 33550335, 16773118, 1'b0);
      add_checked(0, 0, 0, 0, 1'b0);
      add_checked(4095, 0, 4095, 4094, 1'b0);
      add_checked(0, 4095, 33546240, 16769024, 1'b0);

      // oversized values clamp to the same limits
      add_csr(CSR_SRC_WIDTH, 14'h3FFF);
      add_csr(CSR_SRC_HEIGHT, 14'h1FFF);
      add_csr(CSR_LUMA_STRIDE, 14'h3FFF);
      add_csr(CSR_CHROMA_STRIDE, 14'h3FFF);
      add_csr(CSR_OUT_WIDTH, 14'h1FFF);
      add_csr(CSR_OUT_HEIGHT, 14'h3FFF);
      add_checked(4095, 4095, 33550335, 16773118, 1'b0);
      add_item(2048, 1);

      // zero destination size
      add_csr(CSR_OUT_WIDTH, 14'd0);
      add_checked(0, 0, 0, 0, 1'b1);
      add_checked(4095, 4095, 0, 0, 1'b1);
      add_csr(CSR_OUT_WIDTH, 14'd640);
      add_csr(CSR_OUT_HEIGHT, 14'd0);
      add_checked(0, 0, 0, 0, 1'b1);

      // unmapped indexes, odd source width, stride narrower than a row
      add_csr(CSR_SPARE_LO, 14'h2AAA);
      add_csr(CSR_SPARE_HI, 14'h1555);
      add_csr(CSR_OUT_HEIGHT, 14'd480);
      add_csr(CSR_SRC_WIDTH, 14'd1921);
      add_csr(CSR_SRC_HEIGHT, 14'd1080);
      add_csr(CSR_LUMA_STRIDE, 14'd1920);
      add_csr(CSR_CHROMA_STRIDE, 14'd1000);
      add_item(639, 479);
      add_checked(640, 0, 0, 0, 1'b1);
      add_checked(0, 480, 0, 0, 1'b1);
      add_item(1, 1);
      add_item(333, 222);

      // smallest source stretched across the widest destination
      add_csr(CSR_SRC_WIDTH, 14'd2);
      add_csr(CSR_SRC_HEIGHT, 14'd2);
      add_csr(CSR_LUMA_STRIDE, 14'd2);
      add_csr(CSR_CHROMA_STRIDE, 14'd2);
      add_csr(CSR_OUT_WIDTH, CSR_DATA_W'(MAX_DIM));
      add_csr(CSR_OUT_HEIGHT, 14'd1);
      add_checked(4095, 0, 1, 0, 1'b0);
      add_checked(2048, 0, 1, 0, 1'b0);
      add_checked(2047, 0, 0, 0, 1'b0);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            drain();
            write_reg(stim_rows[i].index, stim_rows[i].value);
            wrote = 1'b1;
         end else begin
            if (wrote) settings_used++;
            wrote = 1'b0;
            send_item(stim_rows[i].coord, stim_rows[i].typed, stim_rows[i].golden,
                      pick_gap(1'b0));
         end
      end

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         drain();
         random_setting();
         settings_used++;
         bursty = (phase == 0) || ($urandom_range(3, 0) == 0);
         if (phase == 0) hold_results = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(random_coord(), 1'b0, '0, pick_gap(bursty));
         end
      end

      drain();
      repeat (PIPE_CYCLES) @(posedge clock);
      $display("summary: %0d items over %0d register settings, %0d register writes",
               items_sent, settings_used, csr_writes);
      $display("summary: %0d results checked, %0d out of range, %0d failures",
               results_seen, oor_seen, errors);
      if (errors == 0 && offsets_due.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/nrsa_pkg.sv
design/nrsa_csr.sv
design/nrsa_div_stage.sv
design/nearest_resize_sample_address.sv
dv/tb_top.sv
